### rtl/hdt_pkg.sv
// shared types and codes for the huffman tree build decoder
`default_nettype none
package hdt_pkg;

	localparam int CountW = 32;
	localparam int SymW   = 8;

	// one node table entry
	typedef struct packed {
		logic [CountW-1:0] count;
		logic              leaf;
		logic [SymW-1:0]   idx;
	} node_t;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_BUILD  = 2'd1,
		FUNC_DECODE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		KIND_SYMBOL = 2'd0,
		KIND_READY  = 2'd1,
		KIND_SINGLE = 2'd2
	} kind_t;

	typedef enum logic {
		REG_TOTAL_SYMBOLS  = 1'b0,
		REG_ACTIVE_SYMBOLS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ONE,
		ST_PAIR,
		ST_RD_A,
		ST_RD_B,
		ST_SUM,
		ST_INS_RD,
		ST_INS_CHK,
		ST_ROOT,
		ST_DEC,
		ST_DROOT,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

### rtl/hdt_if.sv
// channel interfaces for the huffman tree build decoder
`default_nettype none
interface hdt_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  leaf_symbol;
	logic [31:0] leaf_count;
	logic        code_bit;
	modport source (output valid, func, leaf_symbol, leaf_count, code_bit, input ready);
	modport sink (input valid, func, leaf_symbol, leaf_count, code_bit, output ready);
endinterface

interface hdt_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] symbol;
	logic       last;
	modport source (output valid, kind, symbol, last, input ready);
	modport sink (input valid, kind, symbol, last, output ready);
endinterface

interface hdt_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/huffman_tree_build_decoder.sv
// huffman decoder with tree builder: top level
//
// Items on the item channel: load a leaf (symbol, count), build the tree,
// or decode one code bit. Results on the result channel: a decoded symbol
// (with last when total_symbols is reached), tree ready, or single symbol.
// Registers total_symbols (index 0) and active_symbols (index 1) are
// written on the cfg channel, always ready; write them only while idle.
// One node table memory with one read and one write port does all the work
// under a small sequencer, so one item is taken at a time. A load writes
// one leaf. A decode bit reads the child slot and steps down; on a leaf it
// instead counts the symbol, reads the root and emits the symbol. A build
// walks the leaf pairs: it reads both counts, forms their saturating sum and
// places the new node by a sorted insert from the end, shifting larger slots
// up; it then reads the root and emits tree ready (single symbol when there
// is only one leaf). The memory read is registered. Reset clears all control
// state and registers but sets active_symbols to 1; node table contents stay
// undefined until loaded. The result register holds one beat; a stalled
// receiver holds the block in its emit step until the register frees.
`default_nettype none
module huffman_tree_build_decoder
	import hdt_pkg::*;
#(
	parameter int MAX_SYMBOLS = 256
) (
	input  wire           clk,
	input  wire           arst_n,
	hdt_item_if.sink      item,
	hdt_result_if.source  result,
	hdt_cfg_if.sink       cfg
);

	localparam int SlotW = $clog2(2 * MAX_SYMBOLS);
	localparam int Depth = 2 ** SlotW;

	state_t            state_q, state_d;
	logic [SlotW-1:0]  filled_q, filled_d;
	logic [SymW-1:0]   cur_q, cur_d;
	logic [31:0]       decoded_q, decoded_d;
	logic [31:0]       total_q;
	logic [8:0]        active_q;
	logic [SlotW:0]    next_q, next_d;
	logic [SlotW-1:0]  pos_q, pos_d;
	logic [CountW-1:0] a_q, a_d;
	logic [CountW-1:0] sum_q, sum_d;
	logic [SymW-1:0]   kidx_q, kidx_d;
	kind_t             pkind_q, pkind_d;
	logic [SymW-1:0]   psym_q, psym_d;
	logic              plast_q, plast_d;
	logic              rvalid_q;
	kind_t             rkind_q;
	logic [SymW-1:0]   rsym_q;
	logic              rlast_q;

	// node table memory
	node_t             mem [Depth];
	node_t             rdata_q;
	logic [SlotW-1:0]  raddr;
	logic [SlotW-1:0]  waddr;
	node_t             wdata;
	logic              we;

	logic [SlotW-1:0]  n;
	logic              built;
	logic              accept;
	logic              emit;
	logic [CountW:0]   add;
	logic [8:0]        dslot;

	// leaf count clamped to 1..MAX_SYMBOLS
	always_comb begin
		if (active_q == 9'd0) begin
			n = SlotW'(1);
		end else if (active_q > 9'(MAX_SYMBOLS)) begin
			n = SlotW'(MAX_SYMBOLS);
		end else begin
			n = SlotW'(active_q);
		end
	end

	assign built  = (n >= SlotW'(2)) && (filled_q == SlotW'({n, 1'b0} - 1'b1));
	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign emit   = (state_q == ST_EMIT) && (!rvalid_q || result.ready);
	assign add    = {1'b0, a_q} + {1'b0, rdata_q.count};
	assign dslot  = {cur_q, 1'b0} - 9'(item.code_bit);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// sequencer: next state and datapath
	always_comb begin
		state_d   = state_q;
		filled_d  = filled_q;
		cur_d     = cur_q;
		decoded_d = decoded_q;
		next_d    = next_q;
		pos_d     = pos_q;
		a_d       = a_q;
		sum_d     = sum_q;
		kidx_d    = kidx_q;
		pkind_d   = pkind_q;
		psym_d    = psym_q;
		plast_d   = plast_q;
		raddr     = '0;
		waddr     = '0;
		wdata     = '0;
		we        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(item.func))
						FUNC_LOAD: begin
							if (filled_q < n) begin
								waddr    = filled_q + 1'b1;
								wdata    = '{count: item.leaf_count, leaf: 1'b1,
									idx: item.leaf_symbol};
								we       = 1'b1;
								filled_d = filled_q + 1'b1;
							end
						end
						FUNC_BUILD: begin
							if (filled_q == n) begin
								decoded_d = '0;
								if (n == SlotW'(1)) begin
									raddr   = SlotW'(1);
									state_d = ST_ONE;
								end else begin
									next_d  = (SlotW+1)'(1);
									state_d = ST_PAIR;
								end
							end
						end
						FUNC_DECODE: begin
							if (built && (decoded_q < total_q)) begin
								raddr   = SlotW'(dslot);
								state_d = ST_DEC;
							end
						end
						default: ;
					endcase
				end
			end
			ST_ONE: begin
				pkind_d = KIND_SINGLE;
				psym_d  = rdata_q.idx;
				plast_d = 1'b0;
				state_d = ST_EMIT;
			end
			// walk the leaf pairs
			ST_PAIR: begin
				if (next_q < {1'b0, filled_q}) begin
					raddr   = next_q[SlotW-1:0];
					state_d = ST_RD_A;
				end else begin
					raddr   = filled_q;
					state_d = ST_ROOT;
				end
			end
			// first count of the pair, fetch the second
			ST_RD_A: begin
				a_d     = rdata_q.count;
				raddr   = next_q[SlotW-1:0] + 1'b1;
				state_d = ST_RD_B;
			end
			// keep the second count on the read port for the sum
			ST_RD_B: begin
				raddr   = next_q[SlotW-1:0] + 1'b1;
				state_d = ST_SUM;
			end
			// saturating sum, open a slot at the end
			ST_SUM: begin
				sum_d    = add[CountW] ? '1 : add[CountW-1:0];
				kidx_d   = SymW'((next_q + 1'b1) >> 1);
				pos_d    = filled_q;
				filled_d = filled_q + 1'b1;
				next_d   = next_q + (SlotW+1)'(2);
				state_d  = ST_INS_RD;
			end
			// sorted insertion from the end
			ST_INS_RD: begin
				if (pos_q == '0) begin
					waddr   = SlotW'(1);
					wdata   = '{count: sum_q, leaf: 1'b0, idx: kidx_q};
					we      = 1'b1;
					state_d = ST_PAIR;
				end else begin
					raddr   = pos_q;
					state_d = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				waddr = pos_q + 1'b1;
				we    = 1'b1;
				if (rdata_q.count > sum_q) begin
					wdata   = rdata_q;
					pos_d   = pos_q - 1'b1;
					state_d = ST_INS_RD;
				end else begin
					wdata   = '{count: sum_q, leaf: 1'b0, idx: kidx_q};
					state_d = ST_PAIR;
				end
			end
			ST_ROOT: begin
				cur_d   = rdata_q.idx;
				pkind_d = KIND_READY;
				psym_d  = '0;
				plast_d = 1'b0;
				state_d = ST_EMIT;
			end
			// one step down the tree
			ST_DEC: begin
				if (rdata_q.leaf) begin
					decoded_d = decoded_q + 1'b1;
					pkind_d   = KIND_SYMBOL;
					psym_d    = rdata_q.idx;
					plast_d   = ((decoded_q + 1'b1) == total_q);
					raddr     = filled_q;
					state_d   = ST_DROOT;
				end else begin
					cur_d   = rdata_q.idx;
					state_d = ST_IDLE;
				end
			end
			ST_DROOT: begin
				cur_d   = rdata_q.idx;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			filled_q  <= '0;
			cur_q     <= '0;
			decoded_q <= '0;
			total_q   <= '0;
			active_q  <= 9'd1;
			next_q    <= '0;
			pos_q     <= '0;
			a_q       <= '0;
			sum_q     <= '0;
			kidx_q    <= '0;
			pkind_q   <= KIND_SYMBOL;
			psym_q    <= '0;
			plast_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			filled_q  <= filled_d;
			cur_q     <= cur_d;
			decoded_q <= decoded_d;
			next_q    <= next_d;
			pos_q     <= pos_d;
			a_q       <= a_d;
			sum_q     <= sum_d;
			kidx_q    <= kidx_d;
			pkind_q   <= pkind_d;
			psym_q    <= psym_d;
			plast_q   <= plast_d;
			if (cfg.valid) begin
				if (reg_idx_t'(cfg.index) == REG_TOTAL_SYMBOLS) begin
					total_q <= cfg.data;
				end else begin
					active_q <= cfg.data[8:0];
				end
			end
		end
	end

	// result register, one beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			rkind_q  <= KIND_SYMBOL;
			rsym_q   <= '0;
			rlast_q  <= 1'b0;
		end else begin
			if (emit) begin
				rvalid_q <= 1'b1;
				rkind_q  <= pkind_q;
				rsym_q   <= psym_q;
				rlast_q  <= plast_q;
			end else if (result.ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	assign result.valid  = rvalid_q;
	assign result.kind   = rkind_q;
	assign result.symbol = rsym_q;
	assign result.last   = rlast_q;

`ifndef NO_ASSERTIONS
	// the insert step never compares past the first slot
	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_CHK) |-> (pos_q != '0))
		else $error("insert compare at slot zero");

	// pair walk always starts on an odd slot
	a_pair_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIR) |-> next_q[0])
		else $error("pair walk on even slot");

	// an emitted result always shows up as valid on the result channel
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result.valid)
		else $error("emitted result lost");
`endif

endmodule
`default_nettype wire
